// ===== rtl/bitmap_slot_allocator_core_assert.svh =====
// Assertion macros shared by the slot allocator RTL.
// No dependencies; include with the bare file name.
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define BSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define BSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bsa_pkg.sv =====
// Shared types, codes and helpers for the bitmap slot allocator.
// No dependencies; imported by the controller and the datapath.
package bsa_pkg;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FREE  = 2'd3;

    localparam int unsigned CFG_W       = 9;
    localparam logic [8:0]  CFG_RST_VAL = 9'd256;
    localparam int unsigned SLOT_W      = 11;
    localparam logic [7:0]  BYTE_FULL   = 8'hFF;
    localparam logic [7:0]  TOP_BIT     = 8'h80;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_step;
        logic emit_full;
        logic emit_range;
        logic emit_alloc;
        logic emit_access;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic limit_zero;
        logic in_range;
        logic chk_hit;
        logic chk_last_full;
    } t_dp_sts;

    function automatic logic [2:0] first_clear(input logic [7:0] v);
        logic [2:0] k;
        k = '0;
        for (int b = 0; b < 8; b++) begin
            if (!v[b]) begin
                k = 3'(7 - b);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/bsa_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bsa_datapath.sv =====
// Datapath of the slot allocator: map RAM, scan counter, result registers.
// Depends on bsa_pkg, bsa_ram and the assertion macro header.
`include "bitmap_slot_allocator_core_assert.svh"

module bsa_datapath #(
    parameter int unsigned MAP_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_bytes_in_use,
    input  logic [1:0]        i_op,
    input  logic [10:0]       i_slot_index,
    input  bsa_pkg::t_dp_cmd  i_cmd,
    output bsa_pkg::t_dp_sts  o_sts,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [10:0]       o_slot,
    output logic              o_in_use
);
    import bsa_pkg::*;

    localparam int unsigned AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int unsigned CW0 = $clog2(MAP_BYTES + 1);
    localparam int unsigned CW  = (CW0 > CFG_W) ? CW0 : CFG_W;

    logic [CFG_W-1:0]  r_cfg;
    logic [1:0]        r_op;
    logic [10:0]       r_idx;
    logic [CW-1:0]     r_cnt;
    logic              r_chk_vld;
    logic [AW-1:0]     r_chk_addr;
    logic              r_done;
    logic [1:0]        r_status;
    logic [10:0]       r_slot;
    logic              r_in_use;

    logic [CW-1:0]     n_cnt;
    logic              n_chk_vld;
    logic [CW-1:0]     limit;
    logic [7:0]        row;
    logic [7:0]        idx_mask;
    logic [2:0]        k;
    logic [7:0]        k_mask;
    logic              issue;
    logic              used;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [7:0]        wdata;
    logic [AW-1:0]     raddr;
    logic [7:0]        rdata;

    assign limit    = (CW'(r_cfg) < CW'(MAP_BYTES)) ? CW'(r_cfg) : CW'(MAP_BYTES);
    assign row      = r_idx[10:3];
    assign idx_mask = TOP_BIT >> r_idx[2:0];
    assign k        = first_clear(rdata);
    assign k_mask   = TOP_BIT >> k;
    assign used     = |(rdata & idx_mask);
    assign issue    = i_cmd.scan_step && (r_cnt < limit);
    assign raddr    = i_cmd.scan_step ? AW'(r_cnt) : AW'(row);

    always_comb begin
        we    = 1'b0;
        waddr = AW'(r_cnt);
        wdata = '0;
        if (i_cmd.clr_step) begin
            we = 1'b1;
        end else if (i_cmd.emit_alloc) begin
            we    = 1'b1;
            waddr = r_chk_addr;
            wdata = rdata | k_mask;
        end else if (i_cmd.emit_access && r_op == OP_RELEASE && used) begin
            we    = 1'b1;
            waddr = AW'(row);
            wdata = rdata & ~idx_mask;
        end
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_chk_vld = 1'b0;
        if (i_cmd.load) begin
            n_cnt = '0;
        end else if (i_cmd.clr_step || issue) begin
            n_cnt = r_cnt + CW'(1);
        end
        if (issue) begin
            n_chk_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= CFG_RST_VAL;
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_bytes_in_use;
            end
            r_cnt     <= n_cnt;
            r_chk_vld <= n_chk_vld;
            r_done    <= i_cmd.emit_full || i_cmd.emit_range ||
                         i_cmd.emit_alloc || i_cmd.emit_access;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_idx <= i_slot_index;
        end
        if (issue) begin
            r_chk_addr <= AW'(r_cnt);
        end
        if (i_cmd.emit_full) begin
            r_status <= ST_FULL;
            r_slot   <= '0;
            r_in_use <= 1'b0;
        end else if (i_cmd.emit_range) begin
            r_status <= ST_RANGE;
            r_slot   <= r_idx;
            r_in_use <= 1'b0;
        end else if (i_cmd.emit_alloc) begin
            r_status <= ST_OK;
            r_slot   <= SLOT_W'({r_chk_addr, k});
            r_in_use <= 1'b0;
        end else if (i_cmd.emit_access) begin
            r_slot <= r_idx;
            if (r_op == OP_RELEASE && !used) begin
                r_status <= ST_FREE;
                r_in_use <= 1'b0;
            end else begin
                r_status <= ST_OK;
                r_in_use <= used;
            end
        end
    end

    bsa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_sts.clr_last      = (r_cnt == CW'(MAP_BYTES - 1));
    assign o_sts.is_alloc      = (r_op == OP_ALLOC);
    assign o_sts.limit_zero    = (limit == '0);
    assign o_sts.in_range      = (CW'(row) < limit);
    assign o_sts.chk_hit       = r_chk_vld && (rdata != BYTE_FULL);
    assign o_sts.chk_last_full = r_chk_vld && (rdata == BYTE_FULL) &&
                                 (CW'(r_chk_addr) == limit - CW'(1));

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = r_slot;
    assign o_in_use = r_in_use;

    `BSA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done, "result strobe held")
    `BSA_ASSERT_NOW(a_alloc_hit, i_clk, i_rst_n, i_cmd.emit_alloc,
        r_chk_vld && rdata != BYTE_FULL, "allocate without a clear bit")
    `BSA_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, i_cmd.scan_step, r_cnt <= limit,
        "scan ran past bytes in use")

endmodule

// ===== rtl/bsa_ctrl.sv =====
// Controller state machine of the slot allocator.
// Depends on bsa_pkg and the assertion macro header.
`include "bitmap_slot_allocator_core_assert.svh"

module bsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bsa_pkg::t_dp_sts  i_sts,
    output bsa_pkg::t_dp_cmd  o_cmd
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ACCESS
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.limit_zero) begin
                        cmd.emit_full = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        cmd.scan_step = 1'b1;
                        n_state       = S_SCAN;
                    end
                end else if (!i_sts.in_range) begin
                    cmd.emit_range = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_ACCESS;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_sts.chk_hit) begin
                    cmd.emit_alloc = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_sts.chk_last_full) begin
                    cmd.emit_full = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_ACCESS: begin
                cmd.emit_access = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;

    `BSA_ASSERT_NOW(a_one_emit, i_clk, i_rst_n, 1'b1,
        $onehot0({cmd.emit_full, cmd.emit_range, cmd.emit_alloc, cmd.emit_access}),
        "more than one result in a cycle")
    `BSA_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n,
        cmd.emit_full || cmd.emit_range || cmd.emit_alloc || cmd.emit_access,
        r_state == S_IDLE, "result without return to idle")
    `BSA_ASSERT_NEXT(a_start_decode, i_clk, i_rst_n, start && !busy,
        r_state == S_DECODE, "accepted transaction not decoded")

endmodule

// ===== rtl/bitmap_slot_allocator_core.sv =====
// Bitmap slot allocator: first-fit allocate, release and query of slots.
// Top level; depends on bsa_pkg, bsa_ctrl, bsa_datapath and bsa_ram.
//
// Command channel: a transaction (i_op, i_slot_index) is taken at a clock edge
// with start high and busy low. Each transaction gives one result on o_status,
// o_slot and o_in_use, shown for one cycle with o_done high; the receiver
// cannot stall it. Configuration: i_cfg_bytes_in_use is written when
// i_cfg_valid and o_cfg_ready are high, only while busy is low.
// After acceptance, release and query are decoded, read the map byte of the slot
// and then give the result; a slot beyond bytes in use gives its result from
// decode. Allocate scans map bytes from byte 0 until one has a clear bit or the
// last byte in use is full; with no byte in use it reports map full from decode.
// Allocate reads one map byte per cycle from the single read port of the map
// RAM, so its cost grows with the position of the first byte with a clear bit.
// One transaction at a time; the next may start in the cycle o_done is high.
// Reset: the configuration returns to 256 bytes and the map RAM is cleared one
// byte per cycle, all MAP_BYTES bytes, with busy high throughout.
module bitmap_slot_allocator_core #(
    parameter int unsigned MAP_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [10:0] i_slot_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_bytes_in_use,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [10:0] o_slot,
    output logic        o_in_use
);
    import bsa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = !busy;

    bsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bsa_datapath #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_bytes_in_use (i_cfg_bytes_in_use),
        .i_op               (i_op),
        .i_slot_index       (i_slot_index),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_slot             (o_slot),
        .o_in_use           (o_in_use)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_slot_allocator_core: directed and random allocate,
// release and query transactions, checked against a cycle-free model of the usage map.
// Depends on bsa_pkg and the allocator RTL.
module tb;
    import bsa_pkg::*;

    localparam int unsigned MAP_BYTES      = 256;
    localparam logic [1:0]  OP_SPARE       = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {REQ_CMD, REQ_CFG, REQ_DRAIN} t_req_kind;

    typedef struct {
        t_req_kind   kind;
        logic [1:0]  op;
        logic [10:0] slot_index;
        logic [8:0]  cfg_value;
        int unsigned idle_pct;
    } t_slot_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] slot;
        logic        in_use;
    } t_slot_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [10:0] i_slot_index;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_bytes_in_use;
    logic        o_done;
    logic [1:0]  o_status;
    logic [10:0] o_slot;
    logic        o_in_use;

    t_slot_req    pending_reqs[$];
    t_slot_result expected_results[$];
    logic [7:0]   usage_map [MAP_BYTES];
    logic [8:0]   map_bytes_cfg;
    int unsigned  mismatch_count;
    int unsigned  idle_cycles;
    int unsigned  live_slots;
    int unsigned  sender_idle_pct;
    bit           cmd_taken;
    bit           cfg_taken;
    bit           timed_out;

    bitmap_slot_allocator_core #(
        .MAP_BYTES(MAP_BYTES)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_slot_index      (i_slot_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_bytes_in_use(i_cfg_bytes_in_use),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_slot            (o_slot),
        .o_in_use          (o_in_use)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_slot_result predict_slot_op(input logic [1:0] op,
                                                     input logic [10:0] idx);
        t_slot_result res;
        int unsigned  limit;
        int unsigned  row;
        int unsigned  bit_pos;
        logic         used;
        limit = (map_bytes_cfg < MAP_BYTES) ? map_bytes_cfg : MAP_BYTES;
        if (op == OP_ALLOC) begin
            res = '{status: ST_FULL, slot: '0, in_use: 1'b0};
            for (int i = 0; i < limit; i++) begin
                for (int k = 0; k < 8; k++) begin
                    if (res.status == ST_FULL && !usage_map[i][7 - k]) begin
                        usage_map[i][7 - k] = 1'b1;
                        res = '{status: ST_OK, slot: 11'(i * 8 + k), in_use: 1'b0};
                    end
                end
            end
            return res;
        end
        row     = idx[10:3];
        bit_pos = 7 - idx[2:0];
        if (row >= limit) begin
            return '{status: ST_RANGE, slot: idx, in_use: 1'b0};
        end
        used = usage_map[row][bit_pos];
        if (op == OP_RELEASE) begin
            if (!used) begin
                return '{status: ST_FREE, slot: idx, in_use: 1'b0};
            end
            usage_map[row][bit_pos] = 1'b0;
        end
        return '{status: ST_OK, slot: idx, in_use: used};
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_cmd(input logic [1:0] op, input logic [10:0] idx);
        t_slot_req req;
        req.kind       = REQ_CMD;
        req.op         = op;
        req.slot_index = idx;
        req.cfg_value  = '0;
        req.idle_pct   = sender_idle_pct;
        pending_reqs.push_back(req);
    endfunction

    function automatic void push_cfg(input logic [8:0] value);
        t_slot_req req;
        req.kind       = REQ_CFG;
        req.op         = OP_QUERY;
        req.slot_index = '0;
        req.cfg_value  = value;
        req.idle_pct   = 0;
        pending_reqs.push_back(req);
    endfunction

    function automatic void push_drain();
        t_slot_req req;
        req.kind       = REQ_DRAIN;
        req.op         = OP_QUERY;
        req.slot_index = '0;
        req.cfg_value  = '0;
        req.idle_pct   = 0;
        pending_reqs.push_back(req);
    endfunction

    // Mostly alloc/release/query on the occupied low slots, with some wild indexes.
    function automatic void gen_random_phase(input int unsigned count, input int unsigned span);
        int unsigned pick;
        int unsigned hi;
        logic [10:0] idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            hi   = (live_slots + 8 < span) ? live_slots + 8 : span - 1;
            if ($urandom_range(4) == 0) begin
                idx = 11'($urandom_range(2047));
            end else begin
                idx = 11'($urandom_range(hi, 0));
            end
            if (pick < 45) begin
                push_cmd(OP_ALLOC, idx);
                if (live_slots < span) begin
                    live_slots++;
                end
            end else if (pick < 75) begin
                push_cmd(OP_RELEASE, idx);
                if (live_slots > 0) begin
                    live_slots--;
                end
            end else if (pick < 95) begin
                push_cmd(OP_QUERY, idx);
            end else begin
                push_cmd(OP_SPARE, idx);
            end
            if ($urandom_range(199) == 0) begin
                push_drain();
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_slot_result want;
        bit           progress;
        progress = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (o_done) begin
                progress = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected, slot", o_slot, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", o_status, want.status);
                    end
                    if (o_slot !== want.slot) begin
                        report_mismatch("slot", o_slot, want.slot);
                    end
                    if (o_in_use !== want.in_use) begin
                        report_mismatch("in_use", o_in_use, want.in_use);
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_slot_op(i_op, i_slot_index));
                cmd_taken = 1'b1;
                progress  = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                map_bytes_cfg = i_cfg_bytes_in_use;
                cfg_taken     = 1'b1;
                progress      = 1'b1;
            end
        end
        if (progress) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    always @(negedge i_clk) begin
        t_slot_req head;
        logic      next_start;
        logic      next_cfg_valid;
        if (i_rst_n === 1'b1) begin
            next_start     = start && !cmd_taken;
            next_cfg_valid = i_cfg_valid && !cfg_taken;
            cmd_taken      = 1'b0;
            cfg_taken      = 1'b0;
            if (!next_start && !next_cfg_valid && pending_reqs.size() != 0) begin
                head = pending_reqs[0];
                case (head.kind)
                    REQ_CMD: begin
                        if ($urandom_range(99) >= head.idle_pct) begin
                            next_start = 1'b1;
                            i_op         <= head.op;
                            i_slot_index <= head.slot_index;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    REQ_CFG: begin
                        if (expected_results.size() == 0 && !busy) begin
                            next_cfg_valid = 1'b1;
                            i_cfg_bytes_in_use <= head.cfg_value;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    default: begin
                        if (expected_results.size() == 0) begin
                            void'(pending_reqs.pop_front());
                        end
                    end
                endcase
            end
            start       <= next_start;
            i_cfg_valid <= next_cfg_valid;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_op               = OP_ALLOC;
        i_slot_index       = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_bytes_in_use = CFG_RST_VAL;
        map_bytes_cfg      = CFG_RST_VAL;
        mismatch_count     = 0;
        idle_cycles        = 0;
        live_slots         = 0;
        timed_out          = 1'b0;
        cmd_taken          = 1'b0;
        cfg_taken          = 1'b0;
        foreach (usage_map[i]) begin
            usage_map[i] = '0;
        end

        sender_idle_pct = 28;
        push_cmd(OP_QUERY, 11'd0);
        push_cmd(OP_QUERY, 11'd2047);
        push_cmd(OP_RELEASE, 11'd0);
        push_cmd(OP_ALLOC, 11'd2047);
        push_cmd(OP_ALLOC, 11'd0);
        push_cmd(OP_QUERY, 11'd1);
        push_cmd(OP_RELEASE, 11'd0);
        push_cmd(OP_SPARE, 11'd1);
        push_cmd(OP_ALLOC, 11'd1234);
        push_cmd(OP_RELEASE, 11'd2047);
        push_cfg(9'd1);
        repeat (7) begin
            push_cmd(OP_ALLOC, 11'd0);
        end
        push_cmd(OP_QUERY, 11'd8);
        push_cmd(OP_RELEASE, 11'd2047);
        push_cmd(OP_QUERY, 11'd7);
        push_cfg(9'd0);
        push_cmd(OP_ALLOC, 11'd0);
        push_cmd(OP_QUERY, 11'd0);
        push_cfg(9'd511);
        push_cmd(OP_QUERY, 11'd2047);
        push_cmd(OP_ALLOC, 11'd0);
        live_slots = 9;

        push_cfg(9'd256);
        gen_random_phase(300, 2048);
        push_cfg(9'd2);
        gen_random_phase(100, 16);
        push_drain();

        sender_idle_pct = 88;
        push_cfg(9'd511);
        gen_random_phase(150, 2048);
        push_cfg(9'd0);
        gen_random_phase(15, 8);
        push_cfg(9'd3);
        gen_random_phase(100, 24);

        sender_idle_pct = 0;
        push_cfg(9'd1);
        gen_random_phase(80, 8);
        push_cfg(9'd256);
        gen_random_phase(180, 2048);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                while (pending_reqs.size() != 0 || start || i_cfg_valid
                       || expected_results.size() != 0) begin
                    @(posedge i_clk);
                end
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            begin
                while (idle_cycles < WATCHDOG_LIMIT) begin
                    @(posedge i_clk);
                end
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
